### src/tcpq_pkg.sv
`default_nettype none

package tcpq_pkg;

    // Operation codes carried by the kind field.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    // Result status codes.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_EMPTY    = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [2:0] STATUS_BADPOS   = 3'd4;

    // Reset value of the max_entries register.
    localparam logic [7:0] MAX_ENTRIES_RESET = 8'd100;

    // Result item as held in the output register.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] found_position;
        logic [7:0] entry_count;
        logic [7:0] priority_count;
        logic       out_priority;
    } tcpq_res_t;

endpackage

`default_nettype wire

### src/two_class_priority_queue_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_kind, s_entry_tag, s_entry_priority, s_position
// m_        out        m_valid / m_ready      m_status, m_out_tag, m_out_priority,
//                                             m_found_position, m_entry_count, m_priority_count
// cfg_      in         cfg_valid / cfg_ready  cfg_data (max_entries)
//
// An item that needs no entry moved (refused add, add at the tail, empty pop, cancel or
// find, bad position) goes straight to the finishing state, which loads its result into
// the output register once that register is free.
// Add in front of others, pop and cancel stream the moved entries through the one RAM,
// one entry read at a time; an add in front writes its own entry last.
// Find reads from the head and stops at the first match or after the last entry.
// A new item is taken only while the sequencer is idle, not while one is in progress.
// Reset is synchronous and active low; the RAM content is not cleared and needs no pass.
// A stalled result sits in the output register; the next item may be taken meanwhile.

module two_class_priority_queue_unit #(
    parameter int CAPACITY = 128,
    parameter int TAG_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_kind,
    input  wire  [TAG_BITS-1:0] s_entry_tag,
    input  wire                 s_entry_priority,
    input  wire  [7:0]          s_position,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [2:0]          m_status,
    output logic [TAG_BITS-1:0] m_out_tag,
    output logic                m_out_priority,
    output logic [7:0]          m_found_position,
    output logic [7:0]          m_entry_count,
    output logic [7:0]          m_priority_count,

    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [7:0]          cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int ENT_W = TAG_BITS + 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [7:0]          max_entries_reg;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    pocc_reg, pocc_next;

    // Operation context held while the sequencer runs.
    logic [1:0]          op_reg, op_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                prio_reg, prio_next;
    logic [IDX_W-1:0]    at_reg, at_next;      // insert slot, or slot being removed
    logic [IDX_W-1:0]    last_reg, last_next;  // last slot to read
    logic [IDX_W-1:0]    ptr_reg, ptr_next;    // next read address
    logic                issue_reg, issue_next;
    logic                pend_reg, pend_next;  // read data returns this cycle
    logic [IDX_W-1:0]    pidx_reg, pidx_next;  // slot of the returning data
    logic                rmp_reg, rmp_next;    // priority mark of the removed entry

    tcpq_pkg::tcpq_res_t res_reg, res_next;
    logic [TAG_BITS-1:0] rtag_reg, rtag_next;

    logic                m_valid_reg, m_valid_next;
    tcpq_pkg::tcpq_res_t mres_reg, mres_next;
    logic [TAG_BITS-1:0] mtag_reg, mtag_next;

    logic                wr_en, rd_en;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    logic [ENT_W-1:0]    wr_data, rd_data;

    logic [CMP_W-1:0]    occ_w, pos_w;
    logic                full_c, rm_prio_c;
    logic [IDX_W-1:0]    occ_m1;
    logic [IDX_W:0]      fpos_c;

    tcpq_ram #(
        .WIDTH(ENT_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign occ_w   = CMP_W'(occ_reg);
    assign pos_w   = CMP_W'(s_position);
    assign occ_m1  = IDX_W'(occ_reg - CNT_W'(1));
    assign full_c  = (occ_w >= CMP_W'(max_entries_reg)) || (occ_w >= CMP_W'(CAPACITY));
    assign rm_prio_c = (pidx_reg == at_reg) ? rd_data[TAG_BITS] : rmp_reg;
    assign fpos_c  = {1'b0, pidx_reg} + {{IDX_W{1'b0}}, 1'b1};

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        pocc_next    = pocc_reg;
        op_next      = op_reg;
        tag_next     = tag_reg;
        prio_next    = prio_reg;
        at_next      = at_reg;
        last_next    = last_reg;
        ptr_next     = ptr_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        rmp_next     = rmp_reg;
        res_next     = res_reg;
        rtag_next    = rtag_reg;
        m_valid_next = m_valid_reg;
        mres_next    = mres_reg;
        mtag_next    = mtag_reg;
        wr_en        = 1'b0;
        wr_addr      = at_reg;
        wr_data      = {prio_reg, tag_reg};
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_kind;
                    tag_next   = s_entry_tag;
                    prio_next  = s_entry_priority;
                    issue_next = 1'b0;
                    res_next   = '0;
                    rtag_next  = '0;
                    state_next = S_DONE;
                    unique case (s_kind)
                        tcpq_pkg::KIND_ADD: begin
                            if (full_c) begin
                                res_next.status = tcpq_pkg::STATUS_FULL;
                            end else if (!s_entry_priority || pocc_reg == occ_reg) begin
                                // Goes at the tail: no entry moves.
                                wr_en     = 1'b1;
                                wr_addr   = IDX_W'(occ_reg);
                                wr_data   = {s_entry_priority, s_entry_tag};
                                occ_next  = occ_reg + CNT_W'(1);
                                if (s_entry_priority) begin
                                    pocc_next = pocc_reg + CNT_W'(1);
                                end
                            end else begin
                                at_next    = IDX_W'(pocc_reg);
                                last_next  = IDX_W'(pocc_reg);
                                ptr_next   = occ_m1;
                                issue_next = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        tcpq_pkg::KIND_FIND: begin
                            if (occ_reg == '0) begin
                                res_next.status = tcpq_pkg::STATUS_NOTFOUND;
                            end else begin
                                ptr_next   = '0;
                                last_next  = occ_m1;
                                issue_next = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        default: begin
                            if (occ_reg == '0) begin
                                res_next.status = tcpq_pkg::STATUS_EMPTY;
                            end else if (s_kind == tcpq_pkg::KIND_CANCEL &&
                                         (pos_w == '0 || pos_w > occ_w)) begin
                                res_next.status = tcpq_pkg::STATUS_BADPOS;
                            end else begin
                                if (s_kind == tcpq_pkg::KIND_POP) begin
                                    at_next = '0;
                                end else begin
                                    at_next = IDX_W'(pos_w - CMP_W'(1));
                                end
                                ptr_next   = at_next;
                                last_next  = occ_m1;
                                issue_next = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                    endcase
                end
            end

            S_RUN: begin
                if (issue_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg;
                    if (ptr_reg == last_reg) begin
                        issue_next = 1'b0;
                    end else if (op_reg == tcpq_pkg::KIND_ADD) begin
                        ptr_next = ptr_reg - IDX_W'(1);
                    end else begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                if (pend_reg) begin
                    unique case (op_reg)
                        tcpq_pkg::KIND_ADD: begin
                            // Move one slot toward the tail, from the tail down.
                            wr_en   = 1'b1;
                            wr_addr = pidx_reg + IDX_W'(1);
                            wr_data = rd_data;
                            if (pidx_reg == at_reg) begin
                                state_next = S_FILL;
                            end
                        end
                        tcpq_pkg::KIND_FIND: begin
                            if (rd_data[TAG_BITS-1:0] == tag_reg) begin
                                res_next.status         = tcpq_pkg::STATUS_OK;
                                res_next.found_position = 8'(fpos_c);
                                issue_next = 1'b0;
                                pend_next  = 1'b0;
                                state_next = S_DONE;
                            end else if (pidx_reg == last_reg) begin
                                res_next.status = tcpq_pkg::STATUS_NOTFOUND;
                                state_next      = S_DONE;
                            end
                        end
                        default: begin
                            if (pidx_reg == at_reg) begin
                                rmp_next = rd_data[TAG_BITS];
                                if (op_reg == tcpq_pkg::KIND_POP) begin
                                    rtag_next             = rd_data[TAG_BITS-1:0];
                                    res_next.out_priority = rd_data[TAG_BITS];
                                end
                            end else begin
                                // Close the gap: move one slot toward the head.
                                wr_en   = 1'b1;
                                wr_addr = pidx_reg - IDX_W'(1);
                                wr_data = rd_data;
                            end
                            if (pidx_reg == last_reg) begin
                                occ_next = occ_reg - CNT_W'(1);
                                if (rm_prio_c && pocc_reg != '0) begin
                                    pocc_next = pocc_reg - CNT_W'(1);
                                end
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_FILL: begin
                wr_en     = 1'b1;
                wr_addr   = at_reg;
                wr_data   = {prio_reg, tag_reg};
                occ_next  = occ_reg + CNT_W'(1);
                pocc_next = pocc_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    mres_next                = res_reg;
                    mres_next.entry_count    = 8'(occ_reg);
                    mres_next.priority_count = 8'(pocc_reg);
                    mtag_next                = rtag_reg;
                    m_valid_next             = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            occ_reg         <= '0;
            pocc_reg        <= '0;
            issue_reg       <= 1'b0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_entries_reg <= tcpq_pkg::MAX_ENTRIES_RESET;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            pocc_reg    <= pocc_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
        at_reg   <= at_next;
        last_reg <= last_next;
        ptr_reg  <= ptr_next;
        pidx_reg <= pidx_next;
        rmp_reg  <= rmp_next;
        res_reg  <= res_next;
        rtag_reg <= rtag_next;
        mres_reg <= mres_next;
        mtag_reg <= mtag_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = mres_reg.status;
    assign m_out_tag        = mtag_reg;
    assign m_out_priority   = mres_reg.out_priority;
    assign m_found_position = mres_reg.found_position;
    assign m_entry_count    = mres_reg.entry_count;
    assign m_priority_count = mres_reg.priority_count;

    // The entry count never passes the RAM depth.
    a_occ_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(occ_reg) <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Priority entries are a subset of all entries.
    a_pocc_le: assert property (@(posedge aclk) disable iff (!aresetn)
        pocc_reg <= occ_reg)
        else $error("priority count above entry count");

    // Read data is only expected while the sequencer runs.
    a_pend_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> state_reg == S_RUN)
        else $error("read return outside run state");

    // A new result is only loaded from the finishing state.
    a_mload: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside finishing state");

endmodule

`default_nettype wire

### src/tcpq_ram.sv
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire  [WIDTH-1:0]             wr_data,
    input  wire                          rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [WIDTH-1:0]             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
